// ===== rtl/core/gcb_pkg.sv =====
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types, constants and step tables for the great-circle bearing unit.
// ----------------------------------------------------------------------------
package gcb_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int ANG_BITS        = 24;
    localparam int TRIG_ITERATIONS = 24;
    localparam int XW              = 34;
    localparam int SQ_W            = 61;
    localparam int SQRT_STEPS      = 31;
    localparam int DIV_STEPS       = 30;
    localparam int BEAR_W          = 25;

    localparam logic signed [XW-1:0] ONE_Q30  = 34'sd1073741824;
    localparam logic signed [XW-1:0] GAIN_Q30 = 34'sd652032874;

    typedef struct packed {
        logic              err;
        logic              fix;
        logic [BEAR_W-1:0] fix_val;
        logic              dl_neg;
    } t_ctl;

    localparam int CTL_W = $bits(t_ctl);

    function automatic logic signed [XW-1:0] atan_step(input int unsigned i);
        logic signed [XW-1:0] v;
        case (i)
            0:       v = 34'sd754974720;
            1:       v = 34'sd445687602;
            2:       v = 34'sd235489088;
            3:       v = 34'sd119537938;
            4:       v = 34'sd60000934;
            5:       v = 34'sd30029717;
            6:       v = 34'sd15018523;
            7:       v = 34'sd7509720;
            8:       v = 34'sd3754917;
            9:       v = 34'sd1877466;
            10:      v = 34'sd938734;
            default: v = XW'(64'd961263669 >> i);
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/great_circle_bearing_unit.sv =====
// ----------------------------------------------------------------------------
// great_circle_bearing_unit
// Throughput: one word per cycle; the whole pipeline advances together and
// stalls only while an output word waits for i_m_tready.
// Reset: synchronous active-low i_rst_n clears all valid flags.
// Initial bearing of point 1 seen from point 2 through CORDIC, root and
// division cell chains.
// ----------------------------------------------------------------------------
module great_circle_bearing_unit #(
    parameter int TRIG_ITERATIONS = gcb_pkg::TRIG_ITERATIONS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,  // lat_a[23:0] lon_a[48:24] lat_b[72:49] lon_b[97:73]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata,  // bearing[24:0]
    output logic         o_m_tuser   // status[0]
);

    localparam int XW  = gcb_pkg::XW;
    localparam int SW  = gcb_pkg::SQ_W;
    localparam int CW  = gcb_pkg::CTL_W;
    localparam int N   = TRIG_ITERATIONS;
    localparam int SH  = gcb_pkg::ANG_BITS - gcb_pkg::FRAC_BITS;
    localparam int NS  = gcb_pkg::SQRT_STEPS;
    localparam int ND  = gcb_pkg::DIV_STEPS;

    localparam logic signed [26:0] D90  = 27'sd90  <<< gcb_pkg::FRAC_BITS;
    localparam logic signed [26:0] D180 = 27'sd180 <<< gcb_pkg::FRAC_BITS;
    localparam logic signed [26:0] D360 = 27'sd360 <<< gcb_pkg::FRAC_BITS;
    localparam logic signed [XW-1:0] A90  = 34'sd90  <<< gcb_pkg::ANG_BITS;
    localparam logic signed [XW-1:0] A180 = 34'sd180 <<< gcb_pkg::ANG_BITS;
    localparam logic signed [XW-1:0] A360 = 34'sd360 <<< gcb_pkg::ANG_BITS;
    localparam logic signed [67:0] ONE_SQ = 68'sd1 <<< 60;

    function automatic logic [XW:0] fold(input logic signed [XW-1:0] a_in);
        logic signed [XW-1:0] a;
        logic                 neg;
        a   = a_in;
        neg = 1'b0;
        for (int k = 0; k < 2; k++) begin
            if (a >= A180) a = a - A360;
            if (a < -A180) a = a + A360;
        end
        if (a > A90) begin
            a   = a - A180;
            neg = 1'b1;
        end else if (a < -A90) begin
            a   = a + A180;
            neg = 1'b1;
        end
        return {neg, a};
    endfunction

    logic en;
    assign en = !o_m_tvalid || i_m_tready;
    assign o_s_tready = en;

    // stage 1: range check, pole cases, longitude wrap
    logic signed [26:0] s_la, s_oa, s_lb, s_ob, s_dl0, s_oaw, s_obw, s_dl;
    logic               s_err, s_wrap;
    gcb_pkg::t_ctl      s_ctl;

    always_comb begin
        s_la   = 27'($signed(i_s_tdata[23:0]));
        s_oa   = 27'($signed(i_s_tdata[48:24]));
        s_lb   = 27'($signed(i_s_tdata[72:49]));
        s_ob   = 27'($signed(i_s_tdata[97:73]));
        s_err  = s_la < -D90 || s_la > D90 || s_lb < -D90 || s_lb > D90 ||
                 s_oa < -D180 || s_oa > D180 || s_ob < -D180 || s_ob > D180;
        s_dl0  = s_oa - s_ob;
        s_wrap = !(s_dl0 < D180 && s_dl0 > -D180);
        s_oaw  = (s_wrap && s_oa < 0) ? s_oa + D360 : s_oa;
        s_obw  = (s_wrap && s_ob < 0) ? s_ob + D360 : s_ob;
        s_dl   = s_oaw - s_obw;
        s_ctl.err     = s_err;
        s_ctl.fix     = s_err || s_lb == D90 || s_lb == -D90;
        s_ctl.fix_val = (!s_err && s_lb == D90) ? gcb_pkg::BEAR_W'(D180) : '0;
        s_ctl.dl_neg  = s_dl < 0;
    end

    logic               r1_valid;
    gcb_pkg::t_ctl      r1_ctl;
    logic signed [26:0] r1_la, r1_lb, r1_dl;

    // stage 2: angle fold
    logic          r2_valid;
    gcb_pkg::t_ctl r2_ctl;
    logic [XW:0]   r2_fa, r2_fb, r2_fd;

    logic signed [XW-1:0] ca_x [0:N], ca_y [0:N], ca_z [0:N];
    logic signed [XW-1:0] cb_x [0:N], cb_y [0:N], cb_z [0:N];
    logic signed [XW-1:0] cd_x [0:N], cd_y [0:N], cd_z [0:N];
    logic [CW:0]          ca_tag [0:N];
    logic                 cb_tag [0:N];
    logic                 cd_tag [0:N];
    logic                 ca_v [0:N];

    assign ca_v[0]   = r2_valid;
    assign ca_tag[0] = {r2_ctl, r2_fa[XW]};
    assign cb_tag[0] = r2_fb[XW];
    assign cd_tag[0] = r2_fd[XW];
    assign ca_x[0] = gcb_pkg::GAIN_Q30;
    assign cb_x[0] = gcb_pkg::GAIN_Q30;
    assign cd_x[0] = gcb_pkg::GAIN_Q30;
    assign ca_y[0] = '0;
    assign cb_y[0] = '0;
    assign cd_y[0] = '0;
    assign ca_z[0] = $signed(r2_fa[XW-1:0]);
    assign cb_z[0] = $signed(r2_fb[XW-1:0]);
    assign cd_z[0] = $signed(r2_fd[XW-1:0]);

    for (genvar g = 0; g < N; g++) begin : g_rot
        gcb_cordic_cell #(.STEP(g), .VECTOR(1'b0), .TAG_W(CW + 1)) u_a (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(ca_v[g]),
            .i_tag(ca_tag[g]), .i_x(ca_x[g]), .i_y(ca_y[g]), .i_z(ca_z[g]),
            .o_valid(ca_v[g+1]), .o_tag(ca_tag[g+1]),
            .o_x(ca_x[g+1]), .o_y(ca_y[g+1]), .o_z(ca_z[g+1])
        );
        gcb_cordic_cell #(.STEP(g), .VECTOR(1'b0), .TAG_W(1)) u_b (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(ca_v[g]),
            .i_tag(cb_tag[g]), .i_x(cb_x[g]), .i_y(cb_y[g]), .i_z(cb_z[g]),
            .o_valid(), .o_tag(cb_tag[g+1]),
            .o_x(cb_x[g+1]), .o_y(cb_y[g+1]), .o_z(cb_z[g+1])
        );
        gcb_cordic_cell #(.STEP(g), .VECTOR(1'b0), .TAG_W(1)) u_d (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(ca_v[g]),
            .i_tag(cd_tag[g]), .i_x(cd_x[g]), .i_y(cd_y[g]), .i_z(cd_z[g]),
            .o_valid(), .o_tag(cd_tag[g+1]),
            .o_x(cd_x[g+1]), .o_y(cd_y[g+1]), .o_z(cd_z[g+1])
        );
    end

    // stage M1: sign fix and first products
    logic signed [XW-1:0] m_sa, m_ca, m_sb, m_cb, m_cd;
    logic signed [67:0]   m_ab, m_cc;
    gcb_pkg::t_ctl        m_ctl;

    always_comb begin
        m_ctl = gcb_pkg::t_ctl'(ca_tag[N][CW:1]);
        m_sa  = ca_tag[N][0] ? -ca_y[N] : ca_y[N];
        m_ca  = ca_tag[N][0] ? -ca_x[N] : ca_x[N];
        m_sb  = cb_tag[N] ? -cb_y[N] : cb_y[N];
        m_cb  = cb_tag[N] ? -cb_x[N] : cb_x[N];
        m_cd  = cd_tag[N] ? -cd_x[N] : cd_x[N];
        m_ab  = m_sa * m_sb;
        m_cc  = m_ca * m_cb;
    end

    logic                 r3_valid;
    gcb_pkg::t_ctl        r3_ctl;
    logic signed [XW-1:0] r3_p1, r3_p2, r3_cd, r3_sa, r3_sb, r3_cb;

    // stage M2: central-angle cosine
    logic signed [67:0] m_pc;
    assign m_pc = r3_p2 * r3_cd;

    logic                 r4_valid;
    gcb_pkg::t_ctl        r4_ctl;
    logic signed [XW-1:0] r4_val, r4_sa, r4_sb, r4_cb;

    // stage M3: range check, sine radicand, numerator product
    logic signed [67:0] m_vv, m_rad, m_bv;
    gcb_pkg::t_ctl      m3_ctl;

    always_comb begin
        m_vv   = r4_val * r4_val;
        m_rad  = ONE_SQ - m_vv;
        m_bv   = r4_sb * r4_val;
        m3_ctl = r4_ctl;
        if (!r4_ctl.fix && (r4_val >= gcb_pkg::ONE_Q30 || r4_val < -gcb_pkg::ONE_Q30)) begin
            m3_ctl.fix     = 1'b1;
            m3_ctl.fix_val = '0;
        end
    end

    logic                 r5_valid;
    gcb_pkg::t_ctl        r5_ctl;
    logic [SW-1:0]        r5_rad;
    logic signed [XW-1:0] r5_nm, r5_sa, r5_cb;

    // first root chain
    logic [SW-1:0]      q1_v [0:NS], q1_r [0:NS];
    logic [CW+2*XW-1:0] q1_tag [0:NS];
    logic               q1_valid [0:NS];

    assign q1_valid[0] = r5_valid;
    assign q1_tag[0]   = {r5_ctl, r5_sa - r5_nm, r5_cb};
    assign q1_v[0]     = r5_rad;
    assign q1_r[0]     = '0;

    for (genvar g = 0; g < NS; g++) begin : g_sq1
        gcb_sqrt_cell #(.STEP(g), .TAG_W(CW + 2 * XW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(q1_valid[g]),
            .i_tag(q1_tag[g]), .i_v(q1_v[g]), .i_r(q1_r[g]),
            .o_valid(q1_valid[g+1]), .o_tag(q1_tag[g+1]),
            .o_v(q1_v[g+1]), .o_r(q1_r[g+1])
        );
    end

    // stage D1: denominator
    logic signed [XW-1:0] d_sth, d_cb;
    logic signed [67:0]   d_prod;

    always_comb begin
        d_sth  = $signed({1'b0, q1_r[NS][XW-2:0]});
        d_cb   = $signed(q1_tag[NS][XW-1:0]);
        d_prod = d_cb * d_sth;
    end

    logic                 r6_valid;
    gcb_pkg::t_ctl        r6_ctl;
    logic signed [XW-1:0] r6_den, r6_num;

    // division chain
    logic [XW-1:0] dv_an, dv_ad;
    logic [XW-1:0] dv_rem [0:ND], dv_den [0:ND];
    logic [ND-1:0] dv_q [0:ND];
    logic [CW+1:0] dv_tag [0:ND];
    logic          dv_valid [0:ND];

    assign dv_an = r6_num < 0 ? XW'(-r6_num) : XW'(r6_num);
    assign dv_ad = r6_den < 0 ? XW'(-r6_den) : XW'(r6_den);

    assign dv_valid[0] = r6_valid;
    assign dv_tag[0]   = {r6_ctl, (r6_num < 0) != (r6_den < 0), dv_an >= dv_ad};
    assign dv_rem[0]   = dv_an;
    assign dv_den[0]   = dv_ad;
    assign dv_q[0]     = '0;

    for (genvar g = 0; g < ND; g++) begin : g_div
        gcb_div_cell #(.TAG_W(CW + 2)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(dv_valid[g]),
            .i_tag(dv_tag[g]), .i_rem(dv_rem[g]), .i_den(dv_den[g]), .i_q(dv_q[g]),
            .o_valid(dv_valid[g+1]), .o_tag(dv_tag[g+1]),
            .o_rem(dv_rem[g+1]), .o_den(dv_den[g+1]), .o_q(dv_q[g+1])
        );
    end

    logic signed [XW-1:0] t_mag, t_val;
    assign t_mag = dv_tag[ND][0] ? gcb_pkg::ONE_Q30 : $signed(XW'(dv_q[ND]));
    assign t_val = dv_tag[ND][1] ? -t_mag : t_mag;

    logic                 r7_valid;
    gcb_pkg::t_ctl        r7_ctl;
    logic signed [XW-1:0] r7_t;

    logic signed [67:0] t_sq, t_rad;
    assign t_sq  = r7_t * r7_t;
    assign t_rad = ONE_SQ - t_sq;

    logic                 r8_valid;
    gcb_pkg::t_ctl        r8_ctl;
    logic [SW-1:0]        r8_rad;
    logic signed [XW-1:0] r8_t;

    // second root chain
    logic [SW-1:0]    q2_v [0:NS], q2_r [0:NS];
    logic [CW+XW-1:0] q2_tag [0:NS];
    logic             q2_valid [0:NS];

    assign q2_valid[0] = r8_valid;
    assign q2_tag[0]   = {r8_ctl, r8_t};
    assign q2_v[0]     = r8_rad;
    assign q2_r[0]     = '0;

    for (genvar g = 0; g < NS; g++) begin : g_sq2
        gcb_sqrt_cell #(.STEP(g), .TAG_W(CW + XW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(q2_valid[g]),
            .i_tag(q2_tag[g]), .i_v(q2_v[g]), .i_r(q2_r[g]),
            .o_valid(q2_valid[g+1]), .o_tag(q2_tag[g+1]),
            .o_v(q2_v[g+1]), .o_r(q2_r[g+1])
        );
    end

    // stage V0: quadrant pre-rotation
    logic signed [XW-1:0] v_t, v_r;
    assign v_t = $signed(q2_tag[NS][XW-1:0]);
    assign v_r = $signed({1'b0, q2_r[NS][XW-2:0]});

    logic          r9_valid;
    gcb_pkg::t_ctl r9_ctl;
    logic signed [XW-1:0] r9_x, r9_y, r9_z;

    logic signed [XW-1:0] vc_x [0:N], vc_y [0:N], vc_z [0:N];
    logic [CW-1:0]        vc_tag [0:N];
    logic                 vc_valid [0:N];

    assign vc_valid[0] = r9_valid;
    assign vc_tag[0]   = r9_ctl;
    assign vc_x[0]     = r9_x;
    assign vc_y[0]     = r9_y;
    assign vc_z[0]     = r9_z;

    for (genvar g = 0; g < N; g++) begin : g_vec
        gcb_cordic_cell #(.STEP(g), .VECTOR(1'b1), .TAG_W(CW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(vc_valid[g]),
            .i_tag(vc_tag[g]), .i_x(vc_x[g]), .i_y(vc_y[g]), .i_z(vc_z[g]),
            .o_valid(vc_valid[g+1]), .o_tag(vc_tag[g+1]),
            .o_x(vc_x[g+1]), .o_y(vc_y[g+1]), .o_z(vc_z[g+1])
        );
    end

    // final: clamp, round, direction
    gcb_pkg::t_ctl              f_ctl;
    logic signed [XW-1:0]       f_z, f_rnd;
    logic [gcb_pkg::BEAR_W-1:0] f_alpha, f_bear;

    always_comb begin
        f_ctl   = gcb_pkg::t_ctl'(vc_tag[N]);
        f_z     = vc_z[N];
        if (f_z < 0) f_z = '0;
        if (f_z > A180) f_z = A180;
        f_rnd   = f_z + (XW'(1) <<< (SH - 1));
        f_alpha = f_rnd[SH +: gcb_pkg::BEAR_W];
        f_bear  = f_ctl.dl_neg ? gcb_pkg::BEAR_W'(D360) - f_alpha : f_alpha;
        if (f_ctl.fix) f_bear = f_ctl.fix_val;
    end

    logic                       r_out_valid;
    logic [gcb_pkg::BEAR_W-1:0] r_out_bear;
    logic                       r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r7_valid    <= 1'b0;
            r8_valid    <= 1'b0;
            r9_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_s_tvalid;
            r2_valid    <= r1_valid;
            r3_valid    <= ca_v[N];
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= q1_valid[NS];
            r7_valid    <= dv_valid[ND];
            r8_valid    <= r7_valid;
            r9_valid    <= q2_valid[NS];
            r_out_valid <= vc_valid[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ctl <= s_ctl;
            r1_la  <= s_la;
            r1_lb  <= s_lb;
            r1_dl  <= s_dl;
            r2_ctl <= r1_ctl;
            r2_fa  <= fold(XW'(r1_la) <<< SH);
            r2_fb  <= fold(XW'(r1_lb) <<< SH);
            r2_fd  <= fold(XW'(r1_dl) <<< SH);
            r3_ctl <= m_ctl;
            r3_p1  <= m_ab[XW+29:30];
            r3_p2  <= m_cc[XW+29:30];
            r3_cd  <= m_cd;
            r3_sa  <= m_sa;
            r3_sb  <= m_sb;
            r3_cb  <= m_cb;
            r4_ctl <= r3_ctl;
            r4_val <= r3_p1 + m_pc[XW+29:30];
            r4_sa  <= r3_sa;
            r4_sb  <= r3_sb;
            r4_cb  <= r3_cb;
            r5_ctl <= m3_ctl;
            r5_rad <= m_rad[SW-1:0];
            r5_nm  <= m_bv[XW+29:30];
            r5_sa  <= r4_sa;
            r5_cb  <= r4_cb;
            r6_ctl <= gcb_pkg::t_ctl'(q1_tag[NS][CW+2*XW-1:2*XW]);
            r6_num <= $signed(q1_tag[NS][2*XW-1:XW]);
            r6_den <= d_prod[XW+29:30];
            r7_ctl <= gcb_pkg::t_ctl'(dv_tag[ND][CW+1:2]);
            r7_t   <= t_val;
            r8_ctl <= r7_ctl;
            r8_rad <= t_rad[SW-1:0];
            r8_t   <= r7_t;
            r9_ctl <= gcb_pkg::t_ctl'(q2_tag[NS][CW+XW-1:XW]);
            if (v_t < 0) begin
                r9_x <= v_r;
                r9_y <= -v_t;
                r9_z <= A90;
            end else begin
                r9_x <= v_t;
                r9_y <= v_r;
                r9_z <= '0;
            end
            r_out_bear <= f_bear;
            r_out_err  <= f_ctl.err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_bear};
    assign o_m_tuser  = r_out_err;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("error word with nonzero bearing");

    a_bear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata <= 32'(D360))
        else $error("bearing beyond 360 degrees");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== rtl/core/gcb_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// gcb_cordic_cell
// One CORDIC micro-rotation in degrees, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module gcb_cordic_cell #(
    parameter int STEP   = 0,
    parameter bit VECTOR = 1'b0,
    parameter int TAG_W  = 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [TAG_W-1:0]               i_tag,
    input  logic signed [gcb_pkg::XW-1:0]  i_x,
    input  logic signed [gcb_pkg::XW-1:0]  i_y,
    input  logic signed [gcb_pkg::XW-1:0]  i_z,
    output logic                           o_valid,
    output logic [TAG_W-1:0]               o_tag,
    output logic signed [gcb_pkg::XW-1:0]  o_x,
    output logic signed [gcb_pkg::XW-1:0]  o_y,
    output logic signed [gcb_pkg::XW-1:0]  o_z
);

    localparam logic signed [gcb_pkg::XW-1:0] ATAN = gcb_pkg::atan_step(STEP);

    logic                          r_valid;
    logic [TAG_W-1:0]              r_tag;
    logic signed [gcb_pkg::XW-1:0] r_x, r_y, r_z;
    logic signed [gcb_pkg::XW-1:0] n_x, n_y, n_z;
    logic signed [gcb_pkg::XW-1:0] dx, dy;
    logic                          up;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        up = VECTOR ? (i_y > 0) : (i_z >= 0);
        if (up ^ VECTOR) begin
            n_x = i_x - dx;
            n_y = i_y + dy;
        end else begin
            n_x = i_x + dx;
            n_y = i_y - dy;
        end
        n_z = ((up && !VECTOR) || (!up && VECTOR)) ? i_z - ATAN : i_z + ATAN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

// ===== rtl/core/gcb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// gcb_sqrt_cell
// One step of the bitwise integer square root.
// ----------------------------------------------------------------------------
module gcb_sqrt_cell #(
    parameter int STEP  = 0,
    parameter int TAG_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [TAG_W-1:0]         i_tag,
    input  logic [gcb_pkg::SQ_W-1:0] i_v,
    input  logic [gcb_pkg::SQ_W-1:0] i_r,
    output logic                     o_valid,
    output logic [TAG_W-1:0]         o_tag,
    output logic [gcb_pkg::SQ_W-1:0] o_v,
    output logic [gcb_pkg::SQ_W-1:0] o_r
);

    localparam logic [gcb_pkg::SQ_W:0] BIT =
        (gcb_pkg::SQ_W+1)'(1) << (gcb_pkg::SQ_W - 1 - 2 * STEP);

    logic                     r_valid;
    logic [TAG_W-1:0]         r_tag;
    logic [gcb_pkg::SQ_W-1:0] r_v, r_r, n_v, n_r;
    logic [gcb_pkg::SQ_W:0]   sum;

    always_comb begin
        sum = {1'b0, i_r} + BIT;
        if ({1'b0, i_v} >= sum) begin
            n_v = gcb_pkg::SQ_W'({1'b0, i_v} - sum);
            n_r = (i_r >> 1) + BIT[gcb_pkg::SQ_W-1:0];
        end else begin
            n_v = i_v;
            n_r = i_r >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_v   <= n_v;
            r_r   <= n_r;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_v     = r_v;
    assign o_r     = r_r;

endmodule

// ===== rtl/core/gcb_div_cell.sv =====
// ----------------------------------------------------------------------------
// gcb_div_cell
// One quotient bit of the restoring division.
// ----------------------------------------------------------------------------
module gcb_div_cell #(
    parameter int TAG_W = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [TAG_W-1:0]              i_tag,
    input  logic [gcb_pkg::XW-1:0]        i_rem,
    input  logic [gcb_pkg::XW-1:0]        i_den,
    input  logic [gcb_pkg::DIV_STEPS-1:0] i_q,
    output logic                          o_valid,
    output logic [TAG_W-1:0]              o_tag,
    output logic [gcb_pkg::XW-1:0]        o_rem,
    output logic [gcb_pkg::XW-1:0]        o_den,
    output logic [gcb_pkg::DIV_STEPS-1:0] o_q
);

    logic                          r_valid;
    logic [TAG_W-1:0]              r_tag;
    logic [gcb_pkg::XW-1:0]        r_rem, r_den, n_rem;
    logic [gcb_pkg::DIV_STEPS-1:0] r_q, n_q;
    logic [gcb_pkg::XW:0]          rem2;

    always_comb begin
        rem2 = {i_rem, 1'b0};
        if (rem2 >= {1'b0, i_den}) begin
            n_rem = gcb_pkg::XW'(rem2 - {1'b0, i_den});
            n_q   = {i_q[gcb_pkg::DIV_STEPS-2:0], 1'b1};
        end else begin
            n_rem = gcb_pkg::XW'(rem2);
            n_q   = {i_q[gcb_pkg::DIV_STEPS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_rem <= n_rem;
            r_den <= i_den;
            r_q   <= n_q;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_rem   = r_rem;
    assign o_den   = r_den;
    assign o_q     = r_q;

endmodule
